// ----- design/sih_pkg.sv -----
// ----------------------------------------------------------------------------
// String intern hash table package
// Shared constants, types and the prime table of the string intern unit.
// ----------------------------------------------------------------------------
package sih_pkg;

   // Table geometry. TABLE_ENTRIES must be a power of two so that the home
   // slot is the low bits of the hash.
   localparam int unsigned TABLE_ENTRIES     = 1024;
   localparam int unsigned IDX_W             = $clog2(TABLE_ENTRIES);
   localparam int unsigned PRIME_COUNT       = 32;
   localparam int unsigned PRIME_W           = $clog2(PRIME_COUNT);
   localparam int unsigned RECORD_ALIGN      = 8;
   localparam int unsigned LENGTH_WORD_BYTES = 8;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned OFFS_W = 32;
   localparam int unsigned LEN_W  = 32;
   // Record arithmetic needs two bits beyond the offset width.
   localparam int unsigned WIDE_W = OFFS_W + 2;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [7:0] PRIMES [PRIME_COUNT] = '{
        8'd2,   8'd3,   8'd5,   8'd7,  8'd11,  8'd13,  8'd17,  8'd19,
       8'd23,  8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,
       8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,
       8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ARENA_START = 1'd0,
      REG_ARENA_END   = 1'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TABLE_FULL = 2'd1,
      STATUS_ARENA_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_ALLOC,
      S_COMMIT,
      S_EMIT
   } fsm_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
      logic [OFFS_W-1:0] offset;
   } slot_type;

endpackage

// ----- design/string_intern_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// String intern hash table unit
// Hashes a string one byte per transfer and, at its last byte, looks the hash
// up in an open-addressed table with linear probing, allocating an aligned
// arena record on a miss.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tdata: char_byte [7:0]; tuser: has_byte; tlast: is_last
//  rsp_    | out       | tdata: interned_id [31:0]; tuser: was_new [0], status [2:1]
//  csr_    | in        | write enable, register index, 32-bit write data
//
// A byte that is not the last one leaves the unit idle, ready for the next
// byte. A last byte starts the lookup: each slot inspected takes a registered
// table read, then the compare; at an empty slot a new record is sized and
// then committed, and the result is handed to the output register. The table
// has a single read and a single write port, which sets the probe rate.
// After reset the unit clears every table entry before it accepts a
// transfer. A stalled result holds in the output register; the result of a
// further lookup waits in the result stage until the register is free.
module string_intern_hash_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // char_byte [7:0]
   input  logic                           req_tuser,   // has_byte
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // interned_id [31:0]
   output logic [2:0]                     rsp_tuser,   // was_new [0], status [2:1]
   input  logic                           csr_we,
   input  logic [sih_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sih_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sih_pkg::*;

   fsm_type            state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [PRIME_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [OFFS_W-1:0]  arena_start_ff, arena_start_in;
   logic [OFFS_W-1:0]  arena_end_ff, arena_end_in;
   logic [OFFS_W-1:0]  next_free_ff, next_free_in;
   logic [IDX_W-1:0]   probe_idx_ff, probe_idx_in;
   logic [IDX_W-1:0]   probe_step_ff, probe_step_in;
   logic [IDX_W-1:0]   clear_idx_ff, clear_idx_in;
   logic [WIDE_W-1:0]  rec_ff, rec_in;
   logic [OFFS_W-1:0]  res_id_ff, res_id_in;
   logic               res_new_ff, res_new_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OFFS_W-1:0]  rsp_id_ff, rsp_id_in;
   logic               rsp_new_ff, rsp_new_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Slot table with one write and one registered read port.
   slot_type           slot_mem [TABLE_ENTRIES];
   slot_type           rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_type           wr_data;

   logic               req_fire;
   logic [HASH_W-1:0]  byte_ext;
   logic [HASH_W-1:0]  prime_ext;
   logic [HASH_W-1:0]  hash_sum;
   logic [WIDE_W-1:0]  rec_end;
   logic [WIDE_W-1:0]  rec_id;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign byte_ext  = {{(HASH_W-8){req_tdata[7]}}, req_tdata};
   assign prime_ext = {{(HASH_W-8){1'b0}}, PRIMES[pos_ff]};
   assign hash_sum  = hash_ff + HASH_W'(byte_ext * prime_ext);

   // Record end: aligned start, length word, the bytes and the terminator.
   assign rec_end = rec_ff + WIDE_W'(LENGTH_WORD_BYTES) + WIDE_W'(len_ff) + WIDE_W'(1);
   assign rec_id  = rec_ff + WIDE_W'(LENGTH_WORD_BYTES);

   always_comb begin
      state_in       = state_ff;
      hash_in        = hash_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      arena_start_in = arena_start_ff;
      arena_end_in   = arena_end_ff;
      next_free_in   = next_free_ff;
      probe_idx_in   = probe_idx_ff;
      probe_step_in  = probe_step_ff;
      clear_idx_in   = clear_idx_ff;
      rec_in         = rec_ff;
      res_id_in      = res_id_ff;
      res_new_in     = res_new_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_id_in      = rsp_id_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_status_in  = rsp_status_ff;
      rd_en          = 1'b0;
      rd_addr        = probe_idx_ff;
      wr_en          = 1'b0;
      wr_addr        = probe_idx_ff;
      wr_data        = '{valid: 1'b1, hash: hash_ff, offset: rec_id[OFFS_W-1:0]};

      unique case (state_ff)
         S_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clear_idx_ff;
            wr_data      = '0;
            clear_idx_in = clear_idx_ff + IDX_W'(1);
            if (clear_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  hash_in = hash_sum;
                  pos_in  = (pos_ff == PRIME_W'(PRIME_COUNT - 1)) ? '0 : pos_ff + PRIME_W'(1);
                  if (len_ff != '1) begin
                     len_in = len_ff + LEN_W'(1);
                  end
               end
               if (req_tlast) begin
                  probe_idx_in  = hash_in[IDX_W-1:0];
                  probe_step_in = '0;
                  state_in      = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!rd_data_ff.valid) begin
               state_in = S_ALLOC;
            end else if (rd_data_ff.hash == hash_ff) begin
               res_id_in     = rd_data_ff.offset;
               res_new_in    = 1'b0;
               res_status_in = STATUS_OK;
               state_in      = S_EMIT;
            end else if (probe_step_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               res_id_in     = '0;
               res_new_in    = 1'b0;
               res_status_in = STATUS_TABLE_FULL;
               state_in      = S_EMIT;
            end else begin
               probe_idx_in  = probe_idx_ff + IDX_W'(1);
               probe_step_in = probe_step_ff + IDX_W'(1);
               state_in      = S_READ;
            end
         end
         S_ALLOC: begin
            // Round the free offset up to the record alignment.
            rec_in   = (WIDE_W'(next_free_ff) + WIDE_W'(RECORD_ALIGN - 1))
                       & ~WIDE_W'(RECORD_ALIGN - 1);
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (rec_end > WIDE_W'(arena_end_ff)) begin
               res_id_in     = '0;
               res_new_in    = 1'b0;
               res_status_in = STATUS_ARENA_FULL;
            end else begin
               wr_en         = 1'b1;
               next_free_in  = rec_end[OFFS_W-1:0];
               res_id_in     = rec_id[OFFS_W-1:0];
               res_new_in    = 1'b1;
               res_status_in = STATUS_OK;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_new_in    = res_new_ff;
               rsp_status_in = res_status_ff;
               hash_in       = '0;
               pos_in        = '0;
               len_in        = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration is to be written by the user only while the unit is idle; the unit does not enforce it.
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_ARENA_START: begin
               arena_start_in = csr_wdata[OFFS_W-1:0];
               next_free_in   = csr_wdata[OFFS_W-1:0];
            end
            REG_ARENA_END: begin
               arena_end_in = csr_wdata[OFFS_W-1:0];
            end
            default: begin
               arena_end_in = arena_end_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         hash_ff        <= '0;
         pos_ff         <= '0;
         len_ff         <= '0;
         arena_start_ff <= '0;
         arena_end_ff   <= '1;
         next_free_ff   <= '0;
         clear_idx_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hash_ff        <= hash_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
         arena_start_ff <= arena_start_in;
         arena_end_ff   <= arena_end_in;
         next_free_ff   <= next_free_in;
         clear_idx_ff   <= clear_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_idx_ff  <= probe_idx_in;
      probe_step_ff <= probe_step_in;
      rec_ff        <= rec_in;
      res_id_ff     <= res_id_in;
      res_new_ff    <= res_new_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_new_ff};

endmodule
